### hdl/assert_macros.svh
// assertion helpers for the checked signed integer alu
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CSIA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CSIA_ASSERT_DLY(name, ante, n, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

### hdl/csia_pkg.sv
// types and codes shared by the checked signed integer alu
// no dependencies
package csia_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_QUO = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [63:0] operand_y;
    logic signed [63:0] operand_x;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } rsp_t;

endpackage

### hdl/csia_mul.sv
// three stage magnitude multiplier with signed overflow check
// depends on nothing; built from four half width partial products
module csia_mul #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             neg_i,
  output logic [WIDTH-1:0] prod_o,
  output logic             ovf_o
);
  localparam int HW = (WIDTH + 1) / 2;
  localparam int PW = 2 * HW;

  logic [PW-1:0]   a_ext, b_ext;
  logic [PW-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic            neg1_q, neg2_q;
  logic [2*PW-1:0] p_d, p_q;
  logic [WIDTH-1:0] prod_q;
  logic             ovf_q;
  logic             hi_nz, lo_ovf;

  assign a_ext = PW'(a_i);
  assign b_ext = PW'(b_i);

  always_ff @(posedge clk_i) begin
    ll_q   <= PW'(a_ext[HW-1:0])  * PW'(b_ext[HW-1:0]);
    lh_q   <= PW'(a_ext[HW-1:0])  * PW'(b_ext[PW-1:HW]);
    hl_q   <= PW'(a_ext[PW-1:HW]) * PW'(b_ext[HW-1:0]);
    hh_q   <= PW'(a_ext[PW-1:HW]) * PW'(b_ext[PW-1:HW]);
    neg1_q <= neg_i;
  end

  assign p_d = (2*PW)'(ll_q) + ((2*PW)'(lh_q) << HW) + ((2*PW)'(hl_q) << HW)
             + ((2*PW)'(hh_q) << PW);

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    neg2_q <= neg1_q;
  end

  assign hi_nz  = |p_q[2*PW-1:WIDTH];
  assign lo_ovf = neg2_q ? (p_q[WIDTH-1] && (|p_q[WIDTH-2:0])) : p_q[WIDTH-1];

  always_ff @(posedge clk_i) begin
    prod_q <= neg2_q ? (WIDTH'(0) - p_q[WIDTH-1:0]) : p_q[WIDTH-1:0];
    ovf_q  <= hi_nz | lo_ovf;
  end

  assign prod_o = prod_q;
  assign ovf_o  = ovf_q;
endmodule

### hdl/csia_div.sv
// restoring divider on magnitudes, one quotient bit per stage
// depends on nothing; one beat per cycle
module csia_div #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] rem_o
);
  logic [WIDTH-1:0] vld_q;
  logic [WIDTH-1:0] rem_q [WIDTH];
  logic [WIDTH-1:0] num_q [WIDTH];
  logic [WIDTH-1:0] den_q [WIDTH];

  for (genvar k = 0; k < WIDTH; k++) begin : g_stage
    logic [WIDTH-1:0] rem_in, num_in, den_in;
    logic             vld_in;
    logic [WIDTH:0]   trial, diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = {rem_in, num_in[WIDTH-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = !diff[WIDTH];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      num_q[k] <= {num_in[WIDTH-2:0], take};
      den_q[k] <= den_in;
    end
  end

  assign valid_o = vld_q[WIDTH-1];
  assign quo_o   = num_q[WIDTH-1];
  assign rem_o   = rem_q[WIDTH-1];
endmodule

### hdl/checked_signed_integer_alu.sv
// checked signed integer alu: add, sub, mul, truncated quotient and remainder
// the result strobe follows the divider stages and an output register; one beat
// accepted every cycle, busy never rises, receiver cannot stall
// reset clears the valid bits only; beats in flight are dropped
// depends on csia_pkg, csia_mul, csia_div and assert_macros.svh
module checked_signed_integer_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  csia_pkg::req_t req_i,
  output logic          result_valid_o,
  output csia_pkg::rsp_t rsp_o
);
  import csia_pkg::*;
  `include "assert_macros.svh"

  localparam int W   = DATA_WIDTH;
  localparam int LAT = W + 3;

  typedef struct packed {
    logic [2:0]   op;
    logic         ny;
    logic         nx;
    logic         xz;
    logic [W-1:0] asr;
    logic         aso;
  } side_t;

  req_t   req_q;
  logic   v0_q, v1_q;
  side_t  s1_d, s1_q;
  logic [W-1:0] ym, xm, my_q, mx_q, sum, dif;
  side_t  side_q [W];
  logic [W-1:0] mprod;
  logic         movf;
  logic [W-1:0] mr_q [W-3];
  logic [W-3-1:0] mo_q;
  logic         dvld;
  logic [W-1:0] dquo, drem;
  side_t        sx;
  logic signed [W-1:0] r;
  logic [1:0]   st;
  logic         negq;
  rsp_t         rsp_q;
  logic         out_v_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v0_q    <= start && !busy;
      v1_q    <= v0_q;
      out_v_q <= dvld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign ym  = req_q.operand_y[W-1:0];
  assign xm  = req_q.operand_x[W-1:0];
  assign sum = ym + xm;
  assign dif = ym - xm;

  always_comb begin
    s1_d.op  = req_q.operation;
    s1_d.ny  = ym[W-1];
    s1_d.nx  = xm[W-1];
    s1_d.xz  = (xm == '0);
    s1_d.asr = '0;
    s1_d.aso = 1'b0;
    case (req_q.operation)
      OP_ADD: begin
        s1_d.asr = sum;
        s1_d.aso = (ym[W-1] == xm[W-1]) && (sum[W-1] != ym[W-1]);
      end
      OP_SUB: begin
        s1_d.asr = dif;
        s1_d.aso = (ym[W-1] != xm[W-1]) && (dif[W-1] != ym[W-1]);
      end
      default: begin
        s1_d.asr = '0;
        s1_d.aso = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    my_q <= ym[W-1] ? (W'(0) - ym) : ym;
    mx_q <= xm[W-1] ? (W'(0) - xm) : xm;
  end

  csia_mul #(.WIDTH(W)) u_mul (
    .clk_i  (clk_i),
    .a_i    (my_q),
    .b_i    (mx_q),
    .neg_i  (s1_q.ny != s1_q.nx),
    .prod_o (mprod),
    .ovf_o  (movf)
  );

  csia_div #(.WIDTH(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   (my_q),
    .den_i   (mx_q),
    .valid_o (dvld),
    .quo_o   (dquo),
    .rem_o   (drem)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= s1_q;
    for (int k = 1; k < W; k++) begin
      side_q[k] <= side_q[k-1];
    end
    mr_q[0] <= mprod;
    mo_q[0] <= movf;
    for (int k = 1; k < W - 3; k++) begin
      mr_q[k] <= mr_q[k-1];
      mo_q[k] <= mo_q[k-1];
    end
  end

  assign sx   = side_q[W-1];
  assign negq = sx.ny != sx.nx;

  always_comb begin
    r  = '0;
    st = ST_OK;
    case (sx.op)
      OP_ADD, OP_SUB: begin
        r  = sx.asr;
        st = sx.aso ? ST_OVF : ST_OK;
      end
      OP_MUL: begin
        r  = mr_q[W-4];
        st = mo_q[W-4] ? ST_OVF : ST_OK;
      end
      OP_QUO: begin
        if (sx.xz) begin
          st = ST_DIV0;
        end else begin
          r  = negq ? (W'(0) - dquo) : dquo;
          st = (!negq && dquo[W-1]) ? ST_OVF : ST_OK;
        end
      end
      OP_REM: begin
        if (sx.xz) begin
          st = ST_DIV0;
        end else begin
          r = sx.ny ? (W'(0) - drem) : drem;
        end
      end
      default: begin
        r  = '0;
        st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rsp_q.result_value <= 64'(r);
    rsp_q.status       <= st;
  end

  assign result_valid_o = out_v_q;
  assign rsp_o          = rsp_q;

  `CSIA_ASSERT_DLY(a_latency, start && !busy, LAT, result_valid_o)
  `CSIA_ASSERT_IMP(a_div0_zero, result_valid_o && rsp_o.status == ST_DIV0,
                   rsp_o.result_value == '0)
  `CSIA_ASSERT_IMP(a_sign_ext, result_valid_o,
                   rsp_o.result_value[63:W-1] == '0 || (&rsp_o.result_value[63:W-1]))

endmodule
